### hdl/pcbs_pkg.sv
// Shared types and constants for the pulse-count backlight stepper.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
package pcbs_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int LEVEL_W = 8;
	localparam int STEP_W  = 6;
	localparam int CFG_W   = 8;
	localparam int CIDX_W  = 3;
	// Signed working width of the pulse remainder.
	localparam int REM_W   = 8;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_MIN_LEVEL    = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_MAX_LEVEL    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_DIMMING_STEP = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_DRIVER_STEPS = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_ENTRIES_USED = 3'd4;

	typedef enum logic [1:0] {
		ACT_OFF    = 2'd0,
		ACT_ENABLE = 2'd1,
		ACT_PULSE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		TUNE_ZERO,
		TUNE_DIM,
		TUNE_ENTRY
	} tune_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_READ,
		ST_CHECK,
		ST_MAX_RD,
		ST_MAX_TAKE,
		ST_PLAN,
		ST_MOD,
		ST_OFF,
		ST_ENABLE,
		ST_PULSE
	} state_t;

	typedef struct packed {
		logic      load;
		logic      tbl_write;
		logic      set_tune;
		tune_sel_t tune_sel;
		logic      idx_clear;
		logic      idx_set_last;
		logic      idx_inc;
		logic      rd_en;
		logic      plan;
		logic      mod_add;
		logic      mod_sub;
		logic      pulse_dec;
	} cmd_t;

	typedef struct packed {
		logic lvl_zero;
		logic lvl_dim;
		logic lvl_max;
		logic n_zero;
		logic hit;
		logic idx_last;
		logic off;
		logic en;
		logic r_neg;
		logic r_ge;
		logic r_zero;
		logic r_one;
	} stat_t;

endpackage

### hdl/pcbs_dp.sv
// Datapath of the backlight stepper: configuration registers, threshold table memory,
// scan index, current-step state and the remainder register. Depends on pcbs_pkg.
module pcbs_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcbs_pkg::cmd_t                 cmd,
	output pcbs_pkg::stat_t                stat,
	input  logic [pcbs_pkg::LEVEL_W-1:0]   level,
	input  logic                           line_sensed_high,
	input  logic [4:0]                     entry_index,
	input  logic [pcbs_pkg::LEVEL_W-1:0]   entry_threshold,
	input  logic [pcbs_pkg::STEP_W-1:0]    entry_step,
	input  logic                           cfg_write,
	input  logic [pcbs_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [pcbs_pkg::CFG_W-1:0]     cfg_data,
	output logic [pcbs_pkg::STEP_W-1:0]    found_step
);

	logic [pcbs_pkg::LEVEL_W-1:0] min_level_q, max_level_q;
	logic [pcbs_pkg::STEP_W-1:0]  dimming_step_q, driver_steps_q, entries_used_q;

	logic [pcbs_pkg::LEVEL_W-1:0] thr_mem [pcbs_pkg::TABLE_DEPTH];
	logic [pcbs_pkg::STEP_W-1:0]  step_mem [pcbs_pkg::TABLE_DEPTH];
	logic [pcbs_pkg::LEVEL_W-1:0] thr_q;
	logic [pcbs_pkg::STEP_W-1:0]  entry_step_q;

	logic [pcbs_pkg::LEVEL_W-1:0] level_q;
	logic                         line_q;
	logic [pcbs_pkg::IDX_W-1:0]   idx_q;
	logic [pcbs_pkg::STEP_W-1:0]  tune_q;
	logic                         known_q;
	logic [pcbs_pkg::STEP_W-1:0]  cur_q;
	logic                         off_q, en_q;
	logic [pcbs_pkg::REM_W-1:0]   rem_q;

	logic [pcbs_pkg::CNT_W-1:0]   n_used;
	logic [pcbs_pkg::STEP_W-1:0]  steps_eff;
	logic                         wr_ok;
	logic [pcbs_pkg::IDX_W-1:0]   wr_addr;
	logic                         plan_off, plan_known, plan_en;
	logic [pcbs_pkg::STEP_W-1:0]  plan_cur;
	logic [pcbs_pkg::REM_W-1:0]   plan_cur_s, plan_diff;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q    <= 8'd30;
			max_level_q    <= 8'd255;
			dimming_step_q <= 6'd1;
			driver_steps_q <= 6'd32;
			entries_used_q <= 6'd23;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pcbs_pkg::CFG_MIN_LEVEL:    min_level_q    <= cfg_data;
				pcbs_pkg::CFG_MAX_LEVEL:    max_level_q    <= cfg_data;
				pcbs_pkg::CFG_DIMMING_STEP: dimming_step_q <= cfg_data[pcbs_pkg::STEP_W-1:0];
				pcbs_pkg::CFG_DRIVER_STEPS: driver_steps_q <= cfg_data[pcbs_pkg::STEP_W-1:0];
				pcbs_pkg::CFG_ENTRIES_USED: entries_used_q <= cfg_data[pcbs_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_used = (32'(entries_used_q) > pcbs_pkg::TABLE_DEPTH)
		? pcbs_pkg::CNT_W'(pcbs_pkg::TABLE_DEPTH) : pcbs_pkg::CNT_W'(entries_used_q);
	assign steps_eff = (driver_steps_q == '0) ? pcbs_pkg::STEP_W'(1) : driver_steps_q;

	assign wr_ok   = 32'(entry_index) < pcbs_pkg::TABLE_DEPTH;
	assign wr_addr = pcbs_pkg::IDX_W'(entry_index);

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.tbl_write && wr_ok) begin
			thr_mem[wr_addr]  <= entry_threshold;
			step_mem[wr_addr] <= entry_step;
		end
		if (cmd.rd_en) begin
			thr_q        <= thr_mem[idx_q];
			entry_step_q <= step_mem[idx_q];
		end
	end

	// Plan of the action sequence, from the state before the request.
	always_comb begin
		plan_off   = !known_q && line_q;
		plan_known = known_q || plan_off;
		plan_cur   = plan_off ? '0 : cur_q;
		plan_en    = plan_known && (plan_cur == '0);
		if (plan_en)
			plan_cur = steps_eff;
		plan_cur_s = plan_known ? pcbs_pkg::REM_W'(plan_cur) : '1;
		plan_diff  = plan_cur_s - pcbs_pkg::REM_W'(tune_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= 1'b0;
		end else if (cmd.plan) begin
			known_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			level_q <= level;
			line_q  <= line_sensed_high;
		end
		if (cmd.idx_clear)
			idx_q <= '0;
		else if (cmd.idx_set_last)
			idx_q <= pcbs_pkg::IDX_W'(n_used - 1'b1);
		else if (cmd.idx_inc)
			idx_q <= idx_q + 1'b1;
		if (cmd.set_tune) begin
			unique case (cmd.tune_sel)
				pcbs_pkg::TUNE_ZERO:  tune_q <= '0;
				pcbs_pkg::TUNE_DIM:   tune_q <= dimming_step_q;
				pcbs_pkg::TUNE_ENTRY: tune_q <= entry_step_q;
				default:              tune_q <= '0;
			endcase
		end
		if (cmd.plan) begin
			cur_q <= tune_q;
			if (tune_q == '0) begin
				off_q <= 1'b1;
				en_q  <= 1'b0;
				rem_q <= '0;
			end else begin
				off_q <= plan_off;
				en_q  <= plan_en;
				rem_q <= plan_diff;
			end
		end else if (cmd.mod_add) begin
			rem_q <= rem_q + pcbs_pkg::REM_W'(steps_eff);
		end else if (cmd.mod_sub) begin
			rem_q <= rem_q - pcbs_pkg::REM_W'(steps_eff);
		end else if (cmd.pulse_dec) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	always_comb begin
		stat.lvl_zero = level_q == '0;
		stat.lvl_dim  = level_q < min_level_q;
		stat.lvl_max  = level_q == max_level_q;
		stat.n_zero   = n_used == '0;
		stat.hit      = level_q <= thr_q;
		stat.idx_last = pcbs_pkg::CNT_W'(idx_q) == (n_used - 1'b1);
		stat.off      = off_q;
		stat.en       = en_q;
		stat.r_neg    = rem_q[pcbs_pkg::REM_W-1];
		stat.r_ge     = !rem_q[pcbs_pkg::REM_W-1] && (rem_q >= pcbs_pkg::REM_W'(steps_eff));
		stat.r_zero   = rem_q == '0;
		stat.r_one    = rem_q == pcbs_pkg::REM_W'(1);
	end

	assign found_step = tune_q;

endmodule

### hdl/pcbs_ctrl.sv
// Controller state machine of the backlight stepper: sequences lookup, table scan,
// remainder loop and action emission. Depends on pcbs_pkg.
module pcbs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 func,
	input  pcbs_pkg::stat_t      stat,
	output pcbs_pkg::cmd_t       cmd,
	output logic                 busy,
	output logic                 result_valid,
	output logic [1:0]           action,
	output logic                 last
);

	pcbs_pkg::state_t    state_q, state_nxt;
	pcbs_pkg::action_t   act;
	logic                accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pcbs_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	assign busy   = state_q != pcbs_pkg::ST_IDLE;
	assign accept = start && !busy;
	assign action = act;

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.tune_sel = pcbs_pkg::TUNE_ZERO;
		result_valid = 1'b0;
		last         = 1'b0;
		act          = pcbs_pkg::ACT_OFF;
		unique case (state_q)
			pcbs_pkg::ST_IDLE: begin
				cmd.load      = accept && !func;
				cmd.tbl_write = accept && func;
				if (accept && !func)
					state_nxt = pcbs_pkg::ST_LOOKUP;
			end
			pcbs_pkg::ST_LOOKUP: begin
				priority if (stat.lvl_zero) begin
					cmd.set_tune = 1'b1;
					state_nxt    = pcbs_pkg::ST_PLAN;
				end else if (stat.lvl_dim) begin
					cmd.set_tune = 1'b1;
					cmd.tune_sel = pcbs_pkg::TUNE_DIM;
					state_nxt    = pcbs_pkg::ST_PLAN;
				end else if (stat.n_zero) begin
					cmd.set_tune = 1'b1;
					state_nxt    = pcbs_pkg::ST_PLAN;
				end else if (stat.lvl_max) begin
					cmd.idx_set_last = 1'b1;
					state_nxt        = pcbs_pkg::ST_MAX_RD;
				end else begin
					cmd.idx_clear = 1'b1;
					state_nxt     = pcbs_pkg::ST_READ;
				end
			end
			pcbs_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = pcbs_pkg::ST_CHECK;
			end
			pcbs_pkg::ST_CHECK: begin
				priority if (stat.hit) begin
					cmd.set_tune = 1'b1;
					cmd.tune_sel = pcbs_pkg::TUNE_ENTRY;
					state_nxt    = pcbs_pkg::ST_PLAN;
				end else if (stat.idx_last) begin
					cmd.set_tune = 1'b1;
					state_nxt    = pcbs_pkg::ST_PLAN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = pcbs_pkg::ST_READ;
				end
			end
			pcbs_pkg::ST_MAX_RD: begin
				cmd.rd_en = 1'b1;
				state_nxt = pcbs_pkg::ST_MAX_TAKE;
			end
			pcbs_pkg::ST_MAX_TAKE: begin
				cmd.set_tune = 1'b1;
				cmd.tune_sel = pcbs_pkg::TUNE_ENTRY;
				state_nxt    = pcbs_pkg::ST_PLAN;
			end
			pcbs_pkg::ST_PLAN: begin
				cmd.plan  = 1'b1;
				state_nxt = pcbs_pkg::ST_MOD;
			end
			pcbs_pkg::ST_MOD: begin
				priority if (stat.r_neg) begin
					cmd.mod_add = 1'b1;
				end else if (stat.r_ge) begin
					cmd.mod_sub = 1'b1;
				end else if (stat.off) begin
					state_nxt = pcbs_pkg::ST_OFF;
				end else if (stat.en) begin
					state_nxt = pcbs_pkg::ST_ENABLE;
				end else if (!stat.r_zero) begin
					state_nxt = pcbs_pkg::ST_PULSE;
				end else begin
					state_nxt = pcbs_pkg::ST_IDLE;
				end
			end
			pcbs_pkg::ST_OFF: begin
				result_valid = 1'b1;
				act          = pcbs_pkg::ACT_OFF;
				last         = !stat.en && stat.r_zero;
				priority if (stat.en)
					state_nxt = pcbs_pkg::ST_ENABLE;
				else if (stat.r_zero)
					state_nxt = pcbs_pkg::ST_IDLE;
				else
					state_nxt = pcbs_pkg::ST_PULSE;
			end
			pcbs_pkg::ST_ENABLE: begin
				result_valid = 1'b1;
				act          = pcbs_pkg::ACT_ENABLE;
				last         = stat.r_zero;
				state_nxt    = stat.r_zero ? pcbs_pkg::ST_IDLE : pcbs_pkg::ST_PULSE;
			end
			pcbs_pkg::ST_PULSE: begin
				result_valid  = 1'b1;
				act           = pcbs_pkg::ACT_PULSE;
				last          = stat.r_one;
				cmd.pulse_dec = 1'b1;
				state_nxt     = stat.r_one ? pcbs_pkg::ST_IDLE : pcbs_pkg::ST_PULSE;
			end
			default: begin
				state_nxt = pcbs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/pulse_count_backlight_stepper_unit.sv
// Top level of the pulse-count backlight stepper: joins the controller and the datapath.
// Depends on pcbs_pkg, pcbs_ctrl and pcbs_dp.
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   -----------------------------------------------
//   input     start, busy               func, level, line_sensed_high, entry_index,
//                                       entry_threshold, entry_step
//   result    result_valid (strobe)     action, last, found_step
//   config    cfg_write                 cfg_index, cfg_data
//
// An item is taken at a clock edge with start high and busy low. A table write item
// finishes in that same cycle. A request passes through a lookup state, a read and a
// check state for each table entry scanned (the table memory has one registered read
// port), a planning state, one step of the remainder loop per add or subtract of the
// driver step count plus one to leave it, and then one action state per action; busy
// stays high throughout.
// Reset clears the configuration to its defaults and marks the driver step unknown;
// the table itself is not cleared. Each action is shown for one cycle and the receiver
// cannot stall it.
module pulse_count_backlight_stepper_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [pcbs_pkg::LEVEL_W-1:0]  level,
	input  logic                          line_sensed_high,
	input  logic [4:0]                    entry_index,
	input  logic [pcbs_pkg::LEVEL_W-1:0]  entry_threshold,
	input  logic [pcbs_pkg::STEP_W-1:0]   entry_step,
	input  logic                          cfg_write,
	input  logic [pcbs_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [pcbs_pkg::CFG_W-1:0]    cfg_data,
	output logic                          result_valid,
	output logic [1:0]                    action,
	output logic                          last,
	output logic [pcbs_pkg::STEP_W-1:0]   found_step
);

	// Commands flow from the controller to the datapath, status flows back.
	pcbs_pkg::cmd_t  cmd;
	pcbs_pkg::stat_t stat;

	// The controller owns the handshake and decides what each result cycle shows.
	pcbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid),
		.action       (action),
		.last         (last)
	);

	// The datapath holds the table, the configuration and the driver step state.
	pcbs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.level            (level),
		.line_sensed_high (line_sensed_high),
		.entry_index      (entry_index),
		.entry_threshold  (entry_threshold),
		.entry_step       (entry_step),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.found_step       (found_step)
	);

endmodule

### hdl/pcbs_checker.sv
// Port-level checks for the backlight stepper, bound to the top level.
// Depends on pcbs_pkg and pulse_count_backlight_stepper_unit.
module pcbs_port_checks (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          func,
	input logic                          result_valid,
	input logic [1:0]                    action,
	input logic                          last,
	input logic [pcbs_pkg::STEP_W-1:0]   found_step
);

	// Results only appear while a request is in progress.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while idle");

	// The final action of a request returns the block to idle.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid && !busy)
		else $error("activity after final action");

	// A table write item completes in the cycle it is taken.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func |=> !busy)
		else $error("table write left block busy");

	// All actions of one request carry the same step.
	a_step_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) |-> found_step == $past(found_step))
		else $error("step changed within a request");

	// An off-hold ends the request whenever the chosen step is zero.
	a_zero_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && found_step == '0 |->
			action == pcbs_pkg::ACT_OFF && last)
		else $error("step zero must give a single off-hold");

endmodule

bind pulse_count_backlight_stepper_unit pcbs_port_checks u_pcbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.result_valid (result_valid),
	.action       (action),
	.last         (last),
	.found_step   (found_step)
);
